// File: design/cges_pkg.sv
package cges_pkg;

  localparam int FRAC_BITS = 24;
  localparam int NUM_BODIES_DEF = 2;
  localparam int WORD_W = 32;
  localparam int MUL_W = WORD_W + 1;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SQ_W = 2 * WORD_W;
  localparam int DIV_W = (WORD_W + FRAC_BITS > 2 * FRAC_BITS + 1) ?
                         (WORD_W + FRAC_BITS) : (2 * FRAC_BITS + 1);

  localparam logic [15:0] MAX_STEP_RST = 16'd3277;
  localparam logic [15:0] GAIN_RST = 16'd655;
  localparam logic CTRL_BODY_RST = 1'b1;

  localparam logic [1:0] CFG_MAX_STEP = 2'd0;
  localparam logic [1:0] CFG_GAIN = 2'd1;
  localparam logic [1:0] CFG_CTRL_BODY = 2'd2;

  localparam logic signed [WORD_W-1:0] ONE_FX = WORD_W'(64'd1 << FRAC_BITS);

endpackage

// File: design/cges_mul.sv
module cges_mul
  import cges_pkg::*;
(
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

// File: design/cges_div.sv
module cges_div
  import cges_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [WORD_W-1:0] divisor,
  output logic              done_r,
  output logic [DIV_W-1:0]  quot
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]  quo_r;
  logic [WORD_W-1:0] rem_r;
  logic [WORD_W-1:0] dsr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic [WORD_W:0]   rem_sh;
  logic [WORD_W+1:0] diff;
  logic              ge;

  assign rem_sh = {rem_r, quo_r[DIV_W-1]};
  assign diff = {1'b0, rem_sh} - {2'b00, dsr_r};
  assign ge = ~diff[WORD_W+1];
  assign quot = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= CNT_W'(DIV_W);
        quo_r <= dividend;
        rem_r <= '0;
        dsr_r <= divisor;
      end else if (busy_r) begin
        rem_r <= ge ? diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// File: design/cges_sqrt.sv
module cges_sqrt
  import cges_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SQ_W-1:0]   operand,
  output logic              done_r,
  output logic [WORD_W-1:0] root
);

  localparam int CNT_W = $clog2(WORD_W + 1);

  logic [SQ_W-1:0]  v_r;
  logic [SQ_W-1:0]  res_r;
  logic [SQ_W-1:0]  bit_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [SQ_W-1:0]  trial;

  assign trial = res_r + bit_r;
  assign root = res_r[WORD_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= CNT_W'(WORD_W);
        v_r <= operand;
        res_r <= '0;
        bit_r <= SQ_W'(1) << (SQ_W - 2);
      end else if (busy_r) begin
        if (v_r >= trial) begin
          v_r <= v_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// File: design/central_gravity_euler_step.sv
// One request advances every body by one semi-implicit Euler step under
// inverse-square attraction to the origin, after an optional thrust kick on
// the controlled body, and yields one result per body in index order. The
// block takes one request at a time; the work for each body is set by a
// 32-step square root and 56-step restoring divisions that share one divider,
// with all products made on one registered 33 by 33 bit multiplier.
module central_gravity_euler_step
  import cges_pkg::*;
#(
  parameter int NUM_BODIES = NUM_BODIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_time_step,
  input  logic signed [1:0]  in_thrust_radial,
  input  logic signed [1:0]  in_thrust_tangential,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_body_index,
  output logic signed [31:0] out_position_x,
  output logic signed [31:0] out_position_y,
  output logic signed [31:0] out_velocity_x,
  output logic signed [31:0] out_velocity_y,
  output logic               out_saturated,
  output logic               out_last_body,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  localparam int BW = (NUM_BODIES > 1) ? $clog2(NUM_BODIES) : 1;
  localparam int ALT = 1 % NUM_BODIES;
  localparam logic [31:0] ACC_MAX = 32'h7fff_ffff;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_U0 = 5'd1;
  localparam logic [4:0] S_U1 = 5'd2;
  localparam logic [4:0] S_U2 = 5'd3;
  localparam logic [4:0] S_U3 = 5'd4;
  localparam logic [4:0] S_U4 = 5'd5;
  localparam logic [4:0] S_U5 = 5'd6;
  localparam logic [4:0] S_T0 = 5'd7;
  localparam logic [4:0] S_T1 = 5'd8;
  localparam logic [4:0] S_T2 = 5'd9;
  localparam logic [4:0] S_T3 = 5'd10;
  localparam logic [4:0] S_T4 = 5'd11;
  localparam logic [4:0] S_G0 = 5'd12;
  localparam logic [4:0] S_G1 = 5'd13;
  localparam logic [4:0] S_G2 = 5'd14;
  localparam logic [4:0] S_G2B = 5'd15;
  localparam logic [4:0] S_G3 = 5'd16;
  localparam logic [4:0] S_G4 = 5'd17;
  localparam logic [4:0] S_G5 = 5'd18;
  localparam logic [4:0] S_G6 = 5'd19;
  localparam logic [4:0] S_G7 = 5'd20;
  localparam logic [4:0] S_G8 = 5'd21;
  localparam logic [4:0] S_G9 = 5'd22;
  localparam logic [4:0] S_G10 = 5'd23;
  localparam logic [4:0] S_G11 = 5'd24;

  typedef struct packed {
    logic [31:0] val;
    logic        ovf;
  } sat_res_t;

  function automatic sat_res_t sat_add(input logic signed [31:0] a,
                                       input logic signed [33:0] b);
    logic signed [34:0] s;
    sat_res_t r;
    s = $signed({{3{a[31]}}, a}) + $signed({b[33], b});
    r.ovf = 1'b0;
    r.val = s[31:0];
    if (s > 35'sd2147483647) begin
      r.val = 32'h7fff_ffff;
      r.ovf = 1'b1;
    end else if (s < -35'sd2147483648) begin
      r.val = 32'h8000_0000;
      r.ovf = 1'b1;
    end
    return r;
  endfunction

  function automatic logic signed [32:0] term(input logic signed [1:0] j,
                                              input logic signed [31:0] u);
    logic signed [32:0] ue;
    ue = {u[31], u};
    if (j == 2'sd1) begin
      return ue;
    end else if (j == -2'sd1) begin
      return 33'sd0 - ue;
    end
    return 33'sd0;
  endfunction

  function automatic logic signed [31:0] signed_quot(input logic signed [31:0] x,
                                                     input logic [DIV_W-1:0] q);
    logic [31:0] q32;
    q32 = q[31:0];
    return x[31] ? $signed(32'd0 - q32) : $signed(q32);
  endfunction

  logic [4:0]  state_r;
  logic [BW-1:0] body_r;
  logic        thr_r;
  logic [15:0] dt_r;
  logic signed [1:0] jr_r;
  logic signed [1:0] jt_r;
  logic [15:0] max_step_r;
  logic [15:0] gain_r;
  logic        ctrl_body_r;

  logic signed [31:0] pos_x_r [NUM_BODIES];
  logic signed [31:0] pos_y_r [NUM_BODIES];
  logic signed [31:0] vel_x_r [NUM_BODIES];
  logic signed [31:0] vel_y_r [NUM_BODIES];
  logic [NUM_BODIES-1:0] sat_r;

  logic [SQ_W-1:0]    r2_r;
  logic [31:0]        rad_r;
  logic signed [31:0] ux_r;
  logic signed [31:0] uy_r;
  logic [31:0]        k_r;
  logic signed [32:0] cx_r;
  logic signed [32:0] cy_r;
  logic [31:0]        inv_r_r;
  logic [31:0]        inv2_r;
  logic signed [32:0] ax_r;
  logic signed [32:0] ay_r;

  logic               out_valid_r;
  logic               out_body_r;
  logic signed [31:0] out_px_r;
  logic signed [31:0] out_py_r;
  logic signed [31:0] out_vx_r;
  logic signed [31:0] out_vy_r;
  logic               out_sat_r;
  logic               out_last_r;

  logic signed [31:0] cur_x;
  logic signed [31:0] cur_y;
  logic signed [31:0] cur_vx;
  logic signed [31:0] cur_vy;
  logic [31:0]        mag_x;
  logic [31:0]        mag_y;
  logic               is_last;

  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]        prod_sh_u;

  logic              sq_start;
  logic              sq_done;
  logic [31:0]       sq_root;
  logic              div_start;
  logic [DIV_W-1:0]  div_dvd;
  logic [31:0]       div_dsr;
  logic              div_done;
  logic [DIV_W-1:0]  div_q;

  logic signed [31:0] sa_a;
  logic signed [33:0] sa_b;
  sat_res_t           sa_res;

  assign cur_x = pos_x_r[body_r];
  assign cur_y = pos_y_r[body_r];
  assign cur_vx = vel_x_r[body_r];
  assign cur_vy = vel_y_r[body_r];
  assign mag_x = cur_x[31] ? (32'd0 - cur_x) : cur_x;
  assign mag_y = cur_y[31] ? (32'd0 - cur_y) : cur_y;
  assign is_last = (body_r == BW'(NUM_BODIES - 1));
  assign prod_sh_u = $unsigned(prod) >> FRAC_BITS;

  cges_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod)
  );

  cges_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sq_start),
    .operand (r2_r + prod[SQ_W-1:0]),
    .done_r  (sq_done),
    .root    (sq_root)
  );

  cges_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done_r   (div_done),
    .quot     (div_q)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_U0: begin
        mul_a = {cur_x[31], cur_x};
        mul_b = {cur_x[31], cur_x};
      end
      S_U1: begin
        mul_a = {cur_y[31], cur_y};
        mul_b = {cur_y[31], cur_y};
      end
      S_T0: begin
        mul_a = {17'd0, gain_r};
        mul_b = {17'd0, dt_r};
      end
      S_T2: begin
        mul_a = {1'b0, k_r};
        mul_b = cx_r;
      end
      S_T3: begin
        mul_a = {1'b0, k_r};
        mul_b = cy_r;
      end
      S_G2: begin
        mul_a = {1'b0, inv_r_r};
        mul_b = {1'b0, inv_r_r};
      end
      S_G3: begin
        mul_a = {ux_r[31], ux_r};
        mul_b = {1'b0, inv2_r};
      end
      S_G4: begin
        mul_a = {uy_r[31], uy_r};
        mul_b = {1'b0, inv2_r};
      end
      S_G6: begin
        mul_a = ax_r;
        mul_b = {17'd0, dt_r};
      end
      S_G7: begin
        mul_a = ay_r;
        mul_b = {17'd0, dt_r};
      end
      S_G8: begin
        mul_a = {cur_vx[31], cur_vx};
        mul_b = {17'd0, dt_r};
      end
      S_G9: begin
        mul_a = {cur_vy[31], cur_vy};
        mul_b = {17'd0, dt_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    sq_start = (state_r == S_U2);
    div_start = 1'b0;
    div_dvd = DIV_W'(1) << (2 * FRAC_BITS);
    div_dsr = rad_r;
    case (state_r)
      S_U3: begin
        div_start = sq_done && (sq_root != 32'd0);
        div_dvd = DIV_W'(mag_x) << FRAC_BITS;
        div_dsr = sq_root;
      end
      S_U4: begin
        div_start = div_done;
        div_dvd = DIV_W'(mag_y) << FRAC_BITS;
      end
      S_G0: begin
        div_start = (rad_r != 32'd0);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_comb begin
    sa_a = cur_vx;
    sa_b = $signed(34'(prod >>> FRAC_BITS));
    case (state_r)
      S_T3: begin
        sa_a = cur_vx;
        sa_b = $signed(34'(prod >>> FRAC_BITS));
      end
      S_T4: begin
        sa_a = cur_vy;
        sa_b = $signed(34'(prod >>> FRAC_BITS));
      end
      S_G7: begin
        sa_a = cur_vx;
        sa_b = $signed(34'(prod >>> 16));
      end
      S_G8: begin
        sa_a = cur_vy;
        sa_b = $signed(34'(prod >>> 16));
      end
      S_G9: begin
        sa_a = cur_x;
        sa_b = $signed(34'(prod >>> 16));
      end
      S_G10: begin
        sa_a = cur_y;
        sa_b = $signed(34'(prod >>> 16));
      end
      default: begin
        sa_a = cur_vx;
        sa_b = '0;
      end
    endcase
    sa_res = sat_add(sa_a, sa_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      body_r <= '0;
      thr_r <= 1'b0;
      max_step_r <= MAX_STEP_RST;
      gain_r <= GAIN_RST;
      ctrl_body_r <= CTRL_BODY_RST;
      sat_r <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_BODIES; i++) begin
        pos_x_r[i] <= (NUM_BODIES > 1 && i == ALT) ? ONE_FX : 32'sd0;
        pos_y_r[i] <= (i == 0) ? ONE_FX : 32'sd0;
        vel_x_r[i] <= (i == 0) ? (32'sd0 - ONE_FX) : 32'sd0;
        vel_y_r[i] <= (NUM_BODIES > 1 && i == ALT) ? ONE_FX : 32'sd0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_STEP: max_step_r <= cfg_wdata;
          CFG_GAIN: gain_r <= cfg_wdata;
          CFG_CTRL_BODY: ctrl_body_r <= cfg_wdata[0];
          default: ;
        endcase
      end

      if (out_valid_r && out_ready && (state_r != S_G11)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            dt_r <= (in_time_step > max_step_r) ? max_step_r : in_time_step;
            jr_r <= (in_thrust_radial == -2'sd2) ? -2'sd1 : in_thrust_radial;
            jt_r <= (in_thrust_tangential == -2'sd2) ? -2'sd1 : in_thrust_tangential;
            sat_r <= '0;
            if (32'(ctrl_body_r) < NUM_BODIES) begin
              body_r <= BW'(ctrl_body_r);
              thr_r <= 1'b1;
            end else begin
              body_r <= '0;
              thr_r <= 1'b0;
            end
            state_r <= S_U0;
          end
        end
        S_U0: state_r <= S_U1;
        S_U1: begin
          r2_r <= prod[SQ_W-1:0];
          state_r <= S_U2;
        end
        S_U2: state_r <= S_U3;
        S_U3: begin
          if (sq_done) begin
            rad_r <= sq_root;
            if (sq_root == 32'd0) begin
              ux_r <= '0;
              uy_r <= '0;
              state_r <= thr_r ? S_T0 : S_G0;
            end else begin
              state_r <= S_U4;
            end
          end
        end
        S_U4: begin
          if (div_done) begin
            ux_r <= signed_quot(cur_x, div_q);
            state_r <= S_U5;
          end
        end
        S_U5: begin
          if (div_done) begin
            uy_r <= signed_quot(cur_y, div_q);
            state_r <= thr_r ? S_T0 : S_G0;
          end
        end
        S_T0: state_r <= S_T1;
        S_T1: begin
          k_r <= 32'(prod >>> (32 - FRAC_BITS));
          cx_r <= term(jr_r, ux_r) - term(jt_r, uy_r);
          cy_r <= term(jr_r, uy_r) + term(jt_r, ux_r);
          state_r <= S_T2;
        end
        S_T2: state_r <= S_T3;
        S_T3: begin
          vel_x_r[body_r] <= sa_res.val;
          sat_r[body_r] <= sat_r[body_r] | sa_res.ovf;
          state_r <= S_T4;
        end
        S_T4: begin
          vel_y_r[body_r] <= sa_res.val;
          sat_r[body_r] <= sat_r[body_r] | sa_res.ovf;
          body_r <= '0;
          thr_r <= 1'b0;
          state_r <= S_U0;
        end
        S_G0: begin
          if (rad_r == 32'd0) begin
            sat_r[body_r] <= 1'b1;
            ax_r <= '0;
            ay_r <= '0;
            state_r <= S_G6;
          end else begin
            state_r <= S_G1;
          end
        end
        S_G1: begin
          if (div_done) begin
            if (div_q[DIV_W-1:32] != '0) begin
              inv2_r <= ACC_MAX;
              sat_r[body_r] <= 1'b1;
              state_r <= S_G3;
            end else begin
              inv_r_r <= div_q[31:0];
              state_r <= S_G2;
            end
          end
        end
        S_G2: state_r <= S_G2B;
        S_G2B: begin
          if (prod_sh_u > PROD_W'(ACC_MAX)) begin
            inv2_r <= ACC_MAX;
            sat_r[body_r] <= 1'b1;
          end else begin
            inv2_r <= prod_sh_u[31:0];
          end
          state_r <= S_G3;
        end
        S_G3: state_r <= S_G4;
        S_G4: begin
          ax_r <= 33'sd0 - $signed(33'(prod >>> FRAC_BITS));
          state_r <= S_G5;
        end
        S_G5: begin
          ay_r <= 33'sd0 - $signed(33'(prod >>> FRAC_BITS));
          state_r <= S_G6;
        end
        S_G6: state_r <= S_G7;
        S_G7: begin
          vel_x_r[body_r] <= sa_res.val;
          sat_r[body_r] <= sat_r[body_r] | sa_res.ovf;
          state_r <= S_G8;
        end
        S_G8: begin
          vel_y_r[body_r] <= sa_res.val;
          sat_r[body_r] <= sat_r[body_r] | sa_res.ovf;
          state_r <= S_G9;
        end
        S_G9: begin
          pos_x_r[body_r] <= sa_res.val;
          sat_r[body_r] <= sat_r[body_r] | sa_res.ovf;
          state_r <= S_G10;
        end
        S_G10: begin
          pos_y_r[body_r] <= sa_res.val;
          sat_r[body_r] <= sat_r[body_r] | sa_res.ovf;
          state_r <= S_G11;
        end
        S_G11: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_body_r <= body_r[0];
            out_px_r <= cur_x;
            out_py_r <= cur_y;
            out_vx_r <= cur_vx;
            out_vy_r <= cur_vy;
            out_sat_r <= sat_r[body_r];
            out_last_r <= is_last;
            if (is_last) begin
              state_r <= S_IDLE;
            end else begin
              body_r <= body_r + 1'b1;
              state_r <= S_U0;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_body_index = out_body_r;
  assign out_position_x = out_px_r;
  assign out_position_y = out_py_r;
  assign out_velocity_x = out_vx_r;
  assign out_velocity_y = out_vy_r;
  assign out_saturated = out_sat_r;
  assign out_last_body = out_last_r;

endmodule

// File: tb/tb_top.sv
module tb_top;
  import cges_pkg::*;

  typedef struct packed {
    logic [15:0]       time_step;
    logic signed [1:0] thrust_radial;
    logic signed [1:0] thrust_tangential;
  } tick_req_t;

  typedef struct packed {
    logic               body_index;
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic signed [31:0] velocity_x;
    logic signed [31:0] velocity_y;
    logic               saturated;
    logic               last_body;
  } body_state_t;

  localparam longint FX_ONE = 64'sd1 << FRAC_BITS;
  localparam longint FX_SAT = 64'sd2147483647;
  localparam int CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] in_time_step = '0;
  logic signed [1:0] in_thrust_radial = '0;
  logic signed [1:0] in_thrust_tangential = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_body_index;
  logic signed [31:0] out_position_x, out_position_y, out_velocity_x, out_velocity_y;
  logic out_saturated, out_last_body;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_MAX_STEP;
  logic [15:0] cfg_wdata = '0;

  tick_req_t pending_ticks[$];
  body_state_t expected_bodies[$];
  tick_req_t tick_on_bus;
  int errors = 0;
  int cycles = 0;
  int in_gap = 0;
  int out_gap = 0;
  bit no_idle = 1'b0;

  logic signed [31:0] pos_x[2], pos_y[2], vel_x[2], vel_y[2];
  logic [15:0] step_max, gain;
  logic ctrl_body;

  central_gravity_euler_step DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int pick_gap();
    if (no_idle) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(5, 60);
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint radius_dir(input int b, output longint ux, output longint uy);
    longint x, y, r;
    longint unsigned xx, yy;
    x = pos_x[b];
    y = pos_y[b];
    xx = x * x;
    yy = y * y;
    r = longint'(int_sqrt(xx + yy));
    ux = 0;
    uy = 0;
    if (r != 0) begin
      ux = (x * FX_ONE) / r;
      uy = (y * FX_ONE) / r;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] add_clamp(input longint a, input longint b,
                                                   inout bit flag);
    longint s;
    s = a + b;
    if (s > FX_SAT) begin
      flag = 1'b1;
      return 32'sh7fffffff;
    end
    if (s < -FX_SAT - 1) begin
      flag = 1'b1;
      return 32'sh80000000;
    end
    return s[31:0];
  endfunction

  function automatic longint thrust_sign(input logic signed [1:0] v);
    longint s;
    s = v;
    return (s < -1) ? -1 : s;
  endfunction

  task automatic predict_tick(input tick_req_t t);
    longint dt, jr, jt, k, ux, uy, r, ax, ay, inv_r, inv_r2;
    longint unsigned q;
    bit sat[2];
    body_state_t res;
    dt = t.time_step;
    if (dt > step_max) dt = step_max;
    jr = thrust_sign(t.thrust_radial);
    jt = thrust_sign(t.thrust_tangential);
    sat[0] = 1'b0;
    sat[1] = 1'b0;
    k = (longint'(gain) * dt) >>> (32 - FRAC_BITS);
    r = radius_dir(ctrl_body, ux, uy);
    vel_x[ctrl_body] = add_clamp(vel_x[ctrl_body],
                                 (k * (jr * ux - jt * uy)) >>> FRAC_BITS, sat[ctrl_body]);
    vel_y[ctrl_body] = add_clamp(vel_y[ctrl_body],
                                 (k * (jr * uy + jt * ux)) >>> FRAC_BITS, sat[ctrl_body]);
    for (int i = 0; i < 2; i++) begin
      ax = 0;
      ay = 0;
      r = radius_dir(i, ux, uy);
      if (r == 0) begin
        sat[i] = 1'b1;
      end else begin
        inv_r = (FX_ONE * FX_ONE) / r;
        if (inv_r >= (64'sd1 << 32)) begin
          inv_r2 = FX_SAT;
          sat[i] = 1'b1;
        end else begin
          q = (longint'(unsigned'(inv_r)) * longint'(unsigned'(inv_r))) >> FRAC_BITS;
          if (q > FX_SAT) begin
            inv_r2 = FX_SAT;
            sat[i] = 1'b1;
          end else begin
            inv_r2 = q;
          end
        end
        ax = -((ux * inv_r2) >>> FRAC_BITS);
        ay = -((uy * inv_r2) >>> FRAC_BITS);
      end
      vel_x[i] = add_clamp(vel_x[i], (ax * dt) >>> 16, sat[i]);
      vel_y[i] = add_clamp(vel_y[i], (ay * dt) >>> 16, sat[i]);
      pos_x[i] = add_clamp(pos_x[i], (longint'(vel_x[i]) * dt) >>> 16, sat[i]);
      pos_y[i] = add_clamp(pos_y[i], (longint'(vel_y[i]) * dt) >>> 16, sat[i]);
      res.body_index = i[0];
      res.position_x = pos_x[i];
      res.position_y = pos_y[i];
      res.velocity_x = vel_x[i];
      res.velocity_y = vel_y[i];
      res.saturated = sat[i];
      res.last_body = (i == 1);
      expected_bodies = {expected_bodies, res};
    end
  endtask

  // The driver presents one request at a time and predicts it on acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_tick(tick_on_bus);
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_ticks.size() > 0) begin
          tick_on_bus = pending_ticks.pop_front();
          in_time_step <= tick_on_bus.time_step;
          in_thrust_radial <= tick_on_bus.thrust_radial;
          in_thrust_tangential <= tick_on_bus.thrust_tangential;
          in_valid <= 1'b1;
          in_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    body_state_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL central_gravity_euler_step");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_bodies.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        e = expected_bodies.pop_front();
        if (out_body_index !== e.body_index) begin
          $error("body_index exp %0d got %0d", e.body_index, out_body_index); errors++;
        end
        if (out_position_x !== e.position_x) begin
          $error("position_x exp %0d got %0d", e.position_x, out_position_x); errors++;
        end
        if (out_position_y !== e.position_y) begin
          $error("position_y exp %0d got %0d", e.position_y, out_position_y); errors++;
        end
        if (out_velocity_x !== e.velocity_x) begin
          $error("velocity_x exp %0d got %0d", e.velocity_x, out_velocity_x); errors++;
        end
        if (out_velocity_y !== e.velocity_y) begin
          $error("velocity_y exp %0d got %0d", e.velocity_y, out_velocity_y); errors++;
        end
        if (out_saturated !== e.saturated) begin
          $error("saturated exp %0d got %0d", e.saturated, out_saturated); errors++;
        end
        if (out_last_body !== e.last_body) begin
          $error("last_body exp %0d got %0d", e.last_body, out_last_body); errors++;
        end
      end
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      out_gap <= pick_gap();
    end
  end

  // Sampled on the falling edge so that every update of the rising edge has settled.
  task automatic wait_idle();
    @(negedge clk);
    while (!(pending_ticks.size() == 0 && !in_valid && expected_bodies.size() == 0))
      @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_MAX_STEP: step_max = val;
      CFG_GAIN: gain = val;
      CFG_CTRL_BODY: ctrl_body = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] ms, input logic [15:0] g, input logic cb);
    wait_idle();
    write_reg(CFG_MAX_STEP, ms);
    write_reg(CFG_GAIN, g);
    write_reg(CFG_CTRL_BODY, {15'd0, cb});
    @(posedge clk);
    cfg_we <= 1'b0;
    no_idle = ($urandom_range(0, 3) == 0);
  endtask

  task automatic queue_random(input int n, input int dt_hi);
    tick_req_t t;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: t.time_step = 16'($urandom_range(0, 65535));
        1: t.time_step = 16'($urandom_range(0, dt_hi));
        default: t.time_step = 16'($urandom_range(dt_hi / 2, dt_hi));
      endcase
      t.thrust_radial = 2'($urandom_range(0, 3));
      t.thrust_tangential = 2'($urandom_range(0, 3));
      pending_ticks = {pending_ticks, t};
    end
  endtask

  initial begin
    tick_req_t t;
    pos_x[0] = 0;      pos_y[0] = FX_ONE; vel_x[0] = -FX_ONE; vel_y[0] = 0;
    pos_x[1] = FX_ONE; pos_y[1] = 0;      vel_x[1] = 0;       vel_y[1] = FX_ONE;
    step_max = MAX_STEP_RST;
    gain = GAIN_RST;
    ctrl_body = CTRL_BODY_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    t.thrust_radial = 0;
    t.thrust_tangential = 0;
    t.time_step = 16'd0;     pending_ticks = {pending_ticks, t};
    t.time_step = 16'hffff;  pending_ticks = {pending_ticks, t};
    t.time_step = 16'd1;     pending_ticks = {pending_ticks, t};
    t.time_step = 16'd3276;  pending_ticks = {pending_ticks, t};
    t.time_step = 16'd3277;  pending_ticks = {pending_ticks, t};
    for (int a = 0; a < 4; a++)
      for (int b = 0; b < 4; b++) begin
        t.time_step = 16'd3000 + 16'(a * 4 + b);
        t.thrust_radial = 2'(a);
        t.thrust_tangential = 2'(b);
        pending_ticks = {pending_ticks, t};
      end
    queue_random(130, 3277);

    set_config(16'd6000, 16'd2000, 1'b0);
    queue_random(100, 6000);

    set_config(16'd0, 16'd0, 1'b1);
    queue_random(40, 100);

    set_config(16'd1500, 16'd30000, 1'b0);
    queue_random(60, 1500);

    set_config(16'hffff, 16'hffff, 1'b1);
    queue_random(100, 65535);

    wait_idle();
    repeat (1500) @(posedge clk);
    if (errors == 0 && expected_bodies.size() == 0) begin
      $display("PASS central_gravity_euler_step");
    end else begin
      $display("FAIL central_gravity_euler_step");
    end
    $finish;
  end

endmodule
